[rtl/core/vnth_pkg.sv]
`default_nettype none
package vnth_pkg;

	localparam int COORD_BITS = 24;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int PROD_W     = COORD_BITS + 17;
	localparam int VAL_W      = 32;
	localparam int W_W        = FRAC_BITS + 1;
	localparam int SUM_W      = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FREQ_COARSE = 3'd0,
		REG_FREQ_MEDIUM = 3'd1,
		REG_FREQ_FINE   = 3'd2,
		REG_AMP_COARSE  = 3'd3,
		REG_AMP_MEDIUM  = 3'd4,
		REG_AMP_FINE    = 3'd5,
		REG_BASE_HEIGHT = 3'd6
	} reg_idx_t;

endpackage
`default_nettype wire

[rtl/core/vnth_octave.sv]
`default_nettype none
// One octave of value noise, eight register stages.
module vnth_octave (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	input  wire logic signed [vnth_pkg::COORD_BITS-1:0] x,
	input  wire logic signed [vnth_pkg::COORD_BITS-1:0] z,
	input  wire logic [15:0]                         freq,
	input  wire logic [4:0]                          amp,
	output logic signed [vnth_pkg::SUM_W-1:0]        scaled,
	output logic                                     out_valid
);
	import vnth_pkg::*;

	logic [7:0] v_q;

	// s1: scaled coordinates
	logic signed [PROD_W-1:0] px_s1, pz_s1;
	// s2: cell, fraction, square of fraction
	logic [31:0] ix_s2, iz_s2;
	logic [FRAC_BITS-1:0] fx_s2, fz_s2;
	logic [2*FRAC_BITS-1:0] fx2r_s2, fz2r_s2;
	// s3: smooth weights, hash n per corner
	logic [W_W-1:0] ux_s3, uz_s3;
	logic [31:0] n_s3 [4];
	// s4: n*n, s5: *15731+789221 , s6: n*() + c
	logic [W_W-1:0] ux_s4, uz_s4, ux_s5, uz_s5, ux_s6, uz_s6, uz_s7;
	logic [31:0] n_s4 [4], n_s5 [4], nn_s4 [4], m_s5 [4];
	logic signed [VAL_W-1:0] cv_s6 [4];
	logic signed [VAL_W-1:0] top_s7, bot_s7, oct_s8;
	logic [4:0] amp_d [8];

	function automatic logic [2*FRAC_BITS-1:0] sq_round(input logic [FRAC_BITS-1:0] f);
		logic [2*FRAC_BITS:0] p;
		p = {1'b0, f} * {1'b0, f} + (33'(1) << (FRAC_BITS - 1));
		return p[2*FRAC_BITS:FRAC_BITS] & {{FRAC_BITS{1'b0}}, {FRAC_BITS{1'b1}}};
	endfunction

	function automatic logic [FRAC_BITS-1:0] frac_of(input logic signed [PROD_W-1:0] p);
		logic [15:0] f16;
		f16 = p[15:0];
		if (FRAC_BITS >= 16)
			return FRAC_BITS'({f16, {(FRAC_BITS - 16 + 1){1'b0}}} >> 1);
		else
			return FRAC_BITS'(f16 >> (16 - FRAC_BITS));
	endfunction

	function automatic logic [W_W-1:0] smooth(input logic [FRAC_BITS-1:0] f2,
			input logic [FRAC_BITS-1:0] f);
		logic [FRAC_BITS+2:0] term;
		logic [2*FRAC_BITS+3:0] p;
		term = (FRAC_BITS+3)'(3) << FRAC_BITS;
		term = term - ({2'b00, f, 1'b0});
		p = {3'b000, f2} * {{(FRAC_BITS+1){1'b0}}, term}
			+ ((2*FRAC_BITS+4)'(1) << (FRAC_BITS - 1));
		return W_W'(p >> FRAC_BITS);
	endfunction

	function automatic logic [31:0] hash_n(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] n;
		n = a + b * 32'd57;
		return (n << 13) ^ n;
	endfunction

	// a + round(u*(b-a)), u in Q1.FRAC_BITS, up to 1.0
	function automatic logic signed [VAL_W-1:0] lerp(input logic signed [VAL_W-1:0] a,
			input logic signed [VAL_W-1:0] b, input logic [W_W-1:0] u);
		logic signed [VAL_W:0] d;
		logic signed [VAL_W+W_W+1:0] p;
		d = (VAL_W+1)'(b) - (VAL_W+1)'(a);
		p = d * $signed({1'b0, u}) + ((VAL_W+W_W+2)'(1) <<< (FRAC_BITS - 1));
		return a + VAL_W'(p >>> FRAC_BITS);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		amp_d[0] <= amp;
		for (int i = 1; i < 8; i++) amp_d[i] <= amp_d[i-1];
		px_s1 <= x * $signed({1'b0, freq});
		pz_s1 <= z * $signed({1'b0, freq});
		// s2
		ix_s2 <= 32'(px_s1 >>> 16);
		iz_s2 <= 32'(pz_s1 >>> 16);
		fx_s2 <= frac_of(px_s1);
		fz_s2 <= frac_of(pz_s1);
		fx2r_s2 <= sq_round(frac_of(px_s1));
		fz2r_s2 <= sq_round(frac_of(pz_s1));
		// s3
		ux_s3 <= smooth(FRAC_BITS'(fx2r_s2), fx_s2);
		uz_s3 <= smooth(FRAC_BITS'(fz2r_s2), fz_s2);
		n_s3[0] <= hash_n(ix_s2, iz_s2);
		n_s3[1] <= hash_n(ix_s2 + 32'd1, iz_s2);
		n_s3[2] <= hash_n(ix_s2, iz_s2 + 32'd1);
		n_s3[3] <= hash_n(ix_s2 + 32'd1, iz_s2 + 32'd1);
		ux_s4 <= ux_s3; uz_s4 <= uz_s3;
		ux_s5 <= ux_s4; uz_s5 <= uz_s4;
		ux_s6 <= ux_s5; uz_s6 <= uz_s5;
		for (int c = 0; c < 4; c++) begin
			nn_s4[c] <= n_s3[c] * n_s3[c];
			n_s4[c]  <= n_s3[c];
			m_s5[c]  <= nn_s4[c] * 32'd15731 + 32'd789221;
			n_s5[c]  <= n_s4[c];
			cv_s6[c] <= 32'sh4000_0000
				- $signed({1'b0, 31'(n_s5[c] * m_s5[c] + 32'd1376312589)});
		end
		top_s7 <= lerp(cv_s6[0], cv_s6[1], ux_s6);
		bot_s7 <= lerp(cv_s6[2], cv_s6[3], ux_s6);
		uz_s7  <= uz_s6;
		oct_s8 <= lerp(top_s7, bot_s7, uz_s7);
	end

	assign scaled = SUM_W'(oct_s8) * $signed({1'b0, amp_d[7]});
	assign out_valid = v_q[7];
endmodule
`default_nettype wire

[rtl/core/value_noise_terrain_height_top.sv]
`default_nettype none
// Terrain height from three octaves of value noise.
// One word per cycle from start to done; busy stays low.
// Octaves run side by side in eight-stage pipes; a sum stage and an output stage follow.
// The receiver cannot stall: done strobes for one cycle with surface_height.
// arst_n clears valid bits and loads the register reset values.
module value_noise_terrain_height_top (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic signed [vnth_pkg::COORD_BITS-1:0] world_x,
	input  wire logic signed [vnth_pkg::COORD_BITS-1:0] world_z,
	output logic                                     done,
	output logic signed [9:0]                        surface_height,
	input  wire logic                                cfg_we,
	input  wire logic [vnth_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  wire logic [vnth_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vnth_pkg::*;

	logic [15:0] freq_q [3];
	logic [4:0]  amp_q [3];
	logic [7:0]  base_q;
	logic signed [SUM_W-1:0] oct_sc [3];
	logic        ov [3];
	logic        sum_valid_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] tr;

	// config word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q[0] <= 16'd1966; freq_q[1] <= 16'd5243; freq_q[2] <= 16'd13107;
			amp_q[0] <= 5'd16; amp_q[1] <= 5'd6; amp_q[2] <= 5'd2;
			base_q <= 8'd60;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_FREQ_COARSE: freq_q[0] <= cfg_data;
				REG_FREQ_MEDIUM: freq_q[1] <= cfg_data;
				REG_FREQ_FINE:   freq_q[2] <= cfg_data;
				REG_AMP_COARSE:  amp_q[0] <= cfg_data[4:0];
				REG_AMP_MEDIUM:  amp_q[1] <= cfg_data[4:0];
				REG_AMP_FINE:    amp_q[2] <= cfg_data[4:0];
				REG_BASE_HEIGHT: base_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	for (genvar o = 0; o < 3; o++) begin : g_oct
		vnth_octave u_oct (
			.clk(clk), .arst_n(arst_n), .in_valid(start),
			.x(world_x), .z(world_z), .freq(freq_q[o]), .amp(amp_q[o]),
			.scaled(oct_sc[o]), .out_valid(ov[o])
		);
	end

	// sum the scaled octaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
			done <= 1'b0;
		end else begin
			sum_valid_q <= ov[0];
			done <= sum_valid_q;
		end
	end

	// truncate toward zero: bias negatives by 2^30-1 before the shift
	assign tr = (sum_q + (sum_q[SUM_W-1] ? SUM_W'(32'h3FFF_FFFF) : '0)) >>> 30;

	always_ff @(posedge clk) begin
		sum_q <= oct_sc[0] + oct_sc[1] + oct_sc[2];
		surface_height <= 10'(tr) + 10'({2'b00, base_q});
	end

	assign busy = 1'b0;
	logic unused_ok;
	assign unused_ok = ov[1] ^ ov[2];
endmodule
`default_nettype wire
